### hw/rtl/dpwp_pkg.sv
package dpwp_pkg;

  localparam int unsigned MAX_CHUNK  = 680;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned NRES       = 6;
  localparam int unsigned RES_AW     = $clog2(NRES);
  localparam int unsigned RES_CW     = $clog2(NRES + 1);

  localparam logic [7:0] DCS_COL_ADDR   = 8'h2A;
  localparam logic [7:0] DCS_PAGE_ADDR  = 8'h2B;
  localparam logic [7:0] DCS_WR_FIRST   = 8'h2C;
  localparam logic [7:0] DCS_WR_CONT    = 8'h3C;
  localparam logic [7:0] DT_LONG_WRITE  = 8'h29;
  localparam logic [LEN_W-1:0] ADDR_PKT_LEN = LEN_W'(5);

  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT    = 3'd0,
    REG_CHUNK_PIXELS    = 3'd1,
    REG_GLYPH_THRESHOLD = 3'd2,
    REG_FG_COLOR        = 3'd3,
    REG_BG_COLOR        = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FMT_RGB888 = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_GLYPH  = 2'd2,
    FMT_FILL   = 2'd3
  } pix_fmt_e;

  typedef enum logic {
    KIND_WINDOW = 1'b0,
    KIND_PIXEL  = 1'b1
  } item_kind_e;

  // one queued job for the back end
  typedef struct packed {
    logic             is_win;
    logic [15:0]      x_s;
    logic [15:0]      x_e;
    logic [15:0]      y_s;
    logic [15:0]      y_e;
    logic [23:0]      rgb;
    logic             start;
    logic             first;
    logic             close;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // c * 255 / 31 as 8 * c plus a small correction
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [2:0] k;
    k = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
      + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
    return {c, 3'b000} + 8'(k);
  endfunction

  // g * 255 / 63 as 4 * g plus g / 21
  function automatic logic [7:0] expand6(input logic [5:0] g);
    logic [1:0] k;
    k = 2'(g >= 6'd21) + 2'(g >= 6'd42) + 2'(g >= 6'd63);
    return {g, 2'b00} + 8'(k);
  endfunction

  function automatic logic [31:0] hdr_word(input logic [LEN_W-1:0] len);
    return {8'h00, 16'(len), DT_LONG_WRITE};
  endfunction

endpackage

### hw/rtl/dpwp_pix_if.sv
interface dpwp_pix_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] x_start;
  logic signed [15:0] y_start;
  logic signed [15:0] width;
  logic signed [15:0] height;
  logic [23:0]        pixel;

  modport source (output valid, kind, x_start, y_start, width, height, pixel, input ready);
  modport sink   (input valid, kind, x_start, y_start, width, height, pixel, output ready);
endinterface

### hw/rtl/dpwp_cfg_if.sv
interface dpwp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/dpwp_res_if.sv
interface dpwp_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        is_header;
  logic        last;

  modport source (output valid, word, is_header, last, input ready);
  modport sink   (input valid, word, is_header, last, output ready);
endinterface

### hw/rtl/dpwp_front.sv
module dpwp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  dpwp_pix_if.sink       pix_i,
  dpwp_cfg_if.sink       cfg_i,
  output dpwp_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);
  import dpwp_pkg::*;

  pix_fmt_e    fmt_q;
  logic [9:0]  chunk_q;
  logic [7:0]  thr_q;
  logic [23:0] fg_q;
  logic [23:0] bg_q;

  logic        open_q;
  logic        first_q;
  logic [9:0]  cc_q;
  logic [29:0] pushed_q;
  logic [29:0] total_q;

  logic        acc;
  logic        win_ok;
  logic [15:0] x_u, y_u, w_u, h_u;
  logic [23:0] rgb;
  logic [9:0]  limit;
  logic [9:0]  cc_nxt;
  logic [29:0] pushed_nxt;
  logic        win_done;
  logic        close;

  assign pix_i.ready = cmd_ready_i;
  assign cfg_i.ready = 1'b1;
  assign acc         = pix_i.valid && cmd_ready_i;

  assign x_u    = pix_i.x_start;
  assign y_u    = pix_i.y_start;
  assign w_u    = pix_i.width;
  assign h_u    = pix_i.height;
  assign win_ok = !w_u[15] && (w_u != '0) && !h_u[15] && (h_u != '0);

  always_comb begin
    case (fmt_q)
      FMT_RGB888: rgb = pix_i.pixel;
      FMT_RGB565: rgb = {expand5(pix_i.pixel[15:11]), expand6(pix_i.pixel[10:5]),
                         expand5(pix_i.pixel[4:0])};
      FMT_GLYPH:  rgb = (pix_i.pixel[7:0] >= thr_q) ? fg_q : bg_q;
      default:    rgb = fg_q;
    endcase
  end

  always_comb begin
    if (chunk_q == '0) begin
      limit = 10'd1;
    end else if (chunk_q > 10'(MAX_CHUNK)) begin
      limit = 10'(MAX_CHUNK);
    end else begin
      limit = chunk_q;
    end
  end

  assign cc_nxt     = cc_q + 10'd1;
  assign pushed_nxt = pushed_q + 30'd1;
  assign win_done   = pushed_nxt >= total_q;
  assign close      = (cc_nxt >= limit) || win_done;

  always_comb begin
    cmd_o        = '0;
    cmd_valid_o  = 1'b0;
    if (pix_i.kind == KIND_WINDOW) begin
      cmd_o.is_win = 1'b1;
      cmd_o.x_s    = x_u;
      cmd_o.x_e    = x_u + w_u - 16'd1;
      cmd_o.y_s    = y_u;
      cmd_o.y_e    = y_u + h_u - 16'd1;
      cmd_valid_o  = pix_i.valid && win_ok;
    end else begin
      cmd_o.rgb    = rgb;
      cmd_o.start  = (cc_q == '0);
      cmd_o.first  = first_q;
      cmd_o.close  = close;
      cmd_o.len    = LEN_W'({cc_nxt, 1'b0}) + LEN_W'(cc_nxt) + LEN_W'(1);
      cmd_valid_o  = pix_i.valid && open_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_RGB888;
      chunk_q <= 10'(MAX_CHUNK);
      thr_q   <= '0;
      fg_q    <= '0;
      bg_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_PIXEL_FORMAT:    fmt_q   <= pix_fmt_e'(cfg_i.data[1:0]);
        REG_CHUNK_PIXELS:    chunk_q <= cfg_i.data[9:0];
        REG_GLYPH_THRESHOLD: thr_q   <= cfg_i.data[7:0];
        REG_FG_COLOR:        fg_q    <= cfg_i.data;
        REG_BG_COLOR:        bg_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      first_q  <= 1'b1;
      cc_q     <= '0;
      pushed_q <= '0;
      total_q  <= '0;
    end else if (acc) begin
      if (pix_i.kind == KIND_WINDOW) begin
        if (win_ok) begin
          open_q   <= 1'b1;
          first_q  <= 1'b1;
          cc_q     <= '0;
          pushed_q <= '0;
          total_q  <= 30'(w_u[14:0]) * 30'(h_u[14:0]);
        end
      end else if (open_q) begin
        pushed_q <= pushed_nxt;
        cc_q     <= close ? '0 : cc_nxt;
        if (close) begin
          first_q <= 1'b0;
        end
        if (win_done) begin
          open_q <= 1'b0;
        end
      end
    end
  end

  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (pushed_q < total_q)) else $error("open window already full");

  a_chunk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cc_q < 10'(MAX_CHUNK)) else $error("chunk count out of range");

endmodule

### hw/rtl/dpwp_fifo.sv
module dpwp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dpwp_pkg::cmd_t push_data_i,
  input  logic           push_i,
  output logic           ready_o,
  output dpwp_pkg::cmd_t pop_data_o,
  output logic           valid_o,
  input  logic           pop_i
);
  import dpwp_pkg::*;

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q;
  logic [FIFO_AW-1:0] rd_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               do_push;
  logic               do_pop;

  assign ready_o    = cnt_q != FIFO_CW'(FIFO_DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + FIFO_CW'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CW'(1);
        default: ;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CW'(FIFO_DEPTH)) else $error("queue count overflow");

endmodule

### hw/rtl/dpwp_back.sv
module dpwp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dpwp_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  dpwp_res_if.source     res_o
);
  import dpwp_pkg::*;

  logic [31:0]       shift_q;
  logic [1:0]        phase_q;
  logic [RES_AW-1:0] idx_q;
  logic [RES_AW-1:0] idx_d;

  logic              out_valid_q;
  logic [31:0]       out_word_q;
  logic              out_hdr_q;
  logic              out_last_q;

  logic [7:0]        bytes [4];
  logic [2:0]        nb;
  logic [31:0]       sh;
  logic [1:0]        ph;
  logic              wv;
  logic [31:0]       ww;
  logic [31:0]       fw;

  logic [31:0]       pw [NRES];
  logic              ph_hdr [NRES];
  logic [RES_CW-1:0] pn;
  logic [31:0]       rw [NRES];
  logic              rh [NRES];
  logic [RES_CW-1:0] n;
  logic [31:0]       nxt_shift;
  logic [1:0]        nxt_phase;
  logic              load;
  logic              is_last;

  // byte packing for one pixel
  always_comb begin
    if (cmd_i.start) begin
      sh       = '0;
      ph       = '0;
      bytes[0] = cmd_i.first ? DCS_WR_FIRST : DCS_WR_CONT;
      bytes[1] = cmd_i.rgb[23:16];
      bytes[2] = cmd_i.rgb[15:8];
      bytes[3] = cmd_i.rgb[7:0];
      nb       = 3'd4;
    end else begin
      sh       = shift_q;
      ph       = phase_q;
      bytes[0] = cmd_i.rgb[23:16];
      bytes[1] = cmd_i.rgb[15:8];
      bytes[2] = cmd_i.rgb[7:0];
      bytes[3] = '0;
      nb       = 3'd3;
    end
    wv = 1'b0;
    ww = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < nb) begin
        sh = {bytes[i], sh[31:8]};
        ph = ph + 2'd1;
        if (ph == 2'd0) begin
          wv = 1'b1;
          ww = sh;
        end
      end
    end
    case (ph)
      2'd1:    fw = {24'h0, sh[31:24]};
      2'd2:    fw = {16'h0, sh[31:16]};
      2'd3:    fw = {8'h0, sh[31:8]};
      default: fw = sh;
    endcase
  end

  // result list of a pixel job
  always_comb begin
    for (int i = 0; i < NRES; i++) begin
      pw[i]     = '0;
      ph_hdr[i] = 1'b0;
    end
    pn = '0;
    if (wv) begin
      pw[pn[RES_AW-1:0]] = ww;
      pn = pn + RES_CW'(1);
    end
    if (cmd_i.close && (ph != 2'd0)) begin
      pw[pn[RES_AW-1:0]] = fw;
      pn = pn + RES_CW'(1);
    end
    if (cmd_i.close) begin
      pw[pn[RES_AW-1:0]]     = hdr_word(cmd_i.len);
      ph_hdr[pn[RES_AW-1:0]] = 1'b1;
      pn = pn + RES_CW'(1);
    end
  end

  always_comb begin
    if (cmd_i.is_win) begin
      rw[0] = {cmd_i.x_e[15:8], cmd_i.x_s[7:0], cmd_i.x_s[15:8], DCS_COL_ADDR};
      rw[1] = {24'h0, cmd_i.x_e[7:0]};
      rw[2] = hdr_word(ADDR_PKT_LEN);
      rw[3] = {cmd_i.y_e[15:8], cmd_i.y_s[7:0], cmd_i.y_s[15:8], DCS_PAGE_ADDR};
      rw[4] = {24'h0, cmd_i.y_e[7:0]};
      rw[5] = hdr_word(ADDR_PKT_LEN);
      rh[0] = 1'b0;
      rh[1] = 1'b0;
      rh[2] = 1'b1;
      rh[3] = 1'b0;
      rh[4] = 1'b0;
      rh[5] = 1'b1;
      n         = RES_CW'(NRES);
      nxt_shift = '0;
      nxt_phase = '0;
    end else begin
      rw        = pw;
      rh        = ph_hdr;
      n         = pn;
      nxt_shift = cmd_i.close ? '0 : sh;
      nxt_phase = cmd_i.close ? '0 : ph;
    end
  end

  assign is_last = (RES_CW'(idx_q) + RES_CW'(1)) == n;

  always_comb begin
    load      = 1'b0;
    cmd_pop_o = 1'b0;
    idx_d     = idx_q;
    if (cmd_valid_i) begin
      if (n == '0) begin
        cmd_pop_o = 1'b1;
      end else if (!out_valid_q || res_o.ready) begin
        load = 1'b1;
        if (is_last) begin
          cmd_pop_o = 1'b1;
          idx_d     = '0;
        end else begin
          idx_d = idx_q + RES_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      phase_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cmd_pop_o) begin
        shift_q <= nxt_shift;
        phase_q <= nxt_phase;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q <= rw[idx_q];
      out_hdr_q  <= rh[idx_q];
      out_last_q <= is_last;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.word      = out_word_q;
  assign res_o.is_header = out_hdr_q;
  assign res_o.last      = out_last_q;

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_i |-> (idx_q == '0)) else $error("word index left without a job");

  a_hdr_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_hdr_q) |-> (out_word_q[7:0] == DT_LONG_WRITE))
    else $error("header word without long write code");

endmodule

### hw/rtl/dsi_pixel_window_packetizer_core.sv
// DSI DCS long-write packetizer for pixel windows.
// pix_i takes window and pixel items, cfg_i writes the format, chunk size,
// glyph threshold and colors, res_o gives 32-bit words with is_header and last.
// A window item yields six words: column and page address packets, each a
// payload word, a flush word and a header. A pixel item yields zero to three
// words: a full payload word, and at chunk end a flush word and the header.
// The front end classifies and converts an item in the cycle it is taken and
// queues a job; the back end packs bytes and sends one word per cycle while
// res_o is ready. An item taken while idle goes into the job queue, then the
// output register. Items are taken one per cycle while each yields at most
// one word and res_o is ready; an item yielding k words holds the back end
// until all k are sent, and the four-entry job queue absorbs the difference.
// Reset clears the window, the packing state and the job queue, and sets the
// registers to their defaults (chunk size 680). Config writes are always taken.
// When res_o stalls, the output register holds its word, the queue fills,
// and pix_i.ready drops once the queue is full.
module dsi_pixel_window_packetizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  dpwp_pix_if.sink   pix_i,
  dpwp_cfg_if.sink   cfg_i,
  dpwp_res_if.source res_o
);
  import dpwp_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic q_ready;
  cmd_t head_cmd;
  logic head_valid;
  logic head_pop;

  dpwp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .cfg_i       (cfg_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (q_ready)
  );

  dpwp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_data_i (front_cmd),
    .push_i      (front_valid),
    .ready_o     (q_ready),
    .pop_data_o  (head_cmd),
    .valid_o     (head_valid),
    .pop_i       (head_pop)
  );

  dpwp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (head_valid),
    .cmd_pop_o   (head_pop),
    .res_o       (res_o)
  );

endmodule
